// File: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int FUNC_W   = 1;
  localparam int SIZE_W   = 21;
  localparam int ALIGN_W  = 13;
  localparam int OFFSET_W = 20;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_BAD_FREE   = 2'd3
  } status_t;

endpackage

// File: rtl/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic                               valid;
  logic                               ready;
  logic [ffha_pkg::FUNC_W-1:0]        func;
  logic [ffha_pkg::SIZE_W-1:0]        req_size;
  logic [ffha_pkg::ALIGN_W-1:0]       req_align;
  logic [ffha_pkg::OFFSET_W-1:0]      free_offset;

  modport source (output valid, func, req_size, req_align, free_offset, input ready);
  modport sink   (input valid, func, req_size, req_align, free_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ffha_pkg::OFFSET_W-1:0]      data_offset;
  logic [ffha_pkg::STATUS_W-1:0]      status;

  modport source (output valid, data_offset, status, input ready);
  modport sink   (input valid, data_offset, status, output ready);
endinterface

// File: rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ffha_mod.sv
// ----------------------------------------------------------------------------
// ffha_mod
// Bit-serial remainder unit: dividend mod divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ffha_mod #(
  parameter int N = 21
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [N-1:0]                 dividend,
  input  logic [ffha_pkg::ALIGN_W-1:0] divisor,
  output logic                         done,
  output logic [ffha_pkg::ALIGN_W-1:0] rem
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]                 dvd;
  logic [ffha_pkg::ALIGN_W-1:0] dsr;
  logic [CW-1:0]                cnt;
  logic                         busy;
  logic [ffha_pkg::ALIGN_W:0]   trial;

  assign trial = {rem, dvd[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= CW'(N);
      end else if (busy) begin
        // divisor > 1, so rem stays below it and fits its width
        if (trial >= {1'b0, dsr}) begin
          rem <= ffha_pkg::ALIGN_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[ffha_pkg::ALIGN_W-1:0];
        end
        dvd <= dvd << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing; block list kept in a table RAM.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transfer
//  req     | in  | func, req_size, req_align, free_offset   | valid & ready
//  rsp     | out | data_offset, status                      | valid & ready
//
//  One request at a time. Alloc walks the block list, reading each block from
//  the RAM, runs the remainder unit for every free block large enough when
//  the alignment is above one, then scans for a free table slot and writes
//  the new entries. Free scans the table slot by slot, then merges the block
//  with free next and previous neighbors.
//  After reset the INIT state builds the initial block in slot 0; req is not
//  ready meanwhile. The response sits in an output register, so a stalled
//  rsp blocks only the finish of the following request.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 1048576,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);

  // offsets and sizes never exceed the heap
  localparam int SW   = $clog2(HEAP_BYTES + 1);
  // wide enough for request sizes plus pad and header
  localparam int CW   = ((SW > ffha_pkg::SIZE_W) ? SW : ffha_pkg::SIZE_W) + 2;
  localparam int IW   = $clog2(MAX_BLOCKS);
  // links hold MAX_BLOCKS as null
  localparam int LW   = $clog2(MAX_BLOCKS + 1);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int AW   = ffha_pkg::ALIGN_W;

  typedef struct packed {
    logic [SW-1:0] hdr;
    logic [SW-1:0] size;
    logic          free;
    logic [LW-1:0] next;
    logic [LW-1:0] prev;
  } entry_t;

  typedef enum logic [4:0] {
    INIT, IDLE,
    A_RD, A_CHK, A_MOD, A_SLOT, A_PRD, A_PWR, A_NEW, A_BWR,
    F_RD, F_CK, F_XRD, F_XCK, F_PRE, F_PRD, F_PCK, F_PWR, F_BWR,
    U_RD, U_WR, DONE
  } state_t;

  state_t st, ret;

  logic [MAX_BLOCKS-1:0]        in_use;
  logic [ffha_pkg::SIZE_W-1:0]  rsize;
  logic [AW-1:0]                ralign;
  logic [ffha_pkg::OFFSET_W-1:0] roff;
  logic [LW-1:0]                b;
  logic [IW-1:0]                s;
  logic [IW-1:0]                nb;
  logic [CNTW-1:0]              cnt;
  logic [AW-1:0]                pad;
  entry_t                       cur;
  entry_t                       oth;
  logic [LW-1:0]                ulink;
  logic [LW-1:0]                uval;
  logic [ffha_pkg::OFFSET_W-1:0] res_off;
  logic [ffha_pkg::STATUS_W-1:0] res_st;

  // table RAM ports
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  entry_t        rdata;

  // remainder unit
  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;
  logic [SW:0]   mod_dvd;

  logic [CW-1:0] need;
  logic          fit0;
  logic [AW-1:0] pad_v;
  logic          fit1;
  logic [CW-1:0] alloc_data;
  logic          out_free;

  function automatic logic link_ok(logic [LW-1:0] l, logic [MAX_BLOCKS-1:0] use_v);
    return (l < LW'(MAX_BLOCKS)) && use_v[l[IW-1:0]];
  endfunction

  ffha_ram #(.W($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffha_mod #(.N(SW + 1)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (ralign),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign need      = CW'(rsize) + CW'(HEADER_BYTES);
  assign fit0      = rdata.free && (CW'(rdata.size) >= need);
  assign mod_dvd   = (SW + 1)'(rdata.hdr) + (SW + 1)'(HEADER_BYTES);
  assign mod_start = (st == A_CHK) && fit0 && (ralign > AW'(1));
  assign pad_v     = (mod_rem != '0) ? AW'(ralign - mod_rem) : '0;
  assign fit1      = CW'(cur.size) >= (CW'(pad_v) + need);
  assign alloc_data = CW'(cur.hdr) + CW'(pad) + CW'(HEADER_BYTES);
  assign out_free  = !rsp.valid || rsp.ready;

  assign req.ready = (st == IDLE);

  // read address: data comes back in the state that follows
  always_comb begin
    unique case (st)
      A_RD:    raddr = b[IW-1:0];
      F_RD:    raddr = s;
      F_XRD:   raddr = cur.next[IW-1:0];
      A_PRD,
      F_PRD:   raddr = cur.prev[IW-1:0];
      U_RD:    raddr = ulink[IW-1:0];
      default: raddr = '0;
    endcase
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (st)
      INIT: begin
        we    = 1'b1;
        wdata = '{hdr: '0, size: SW'(HEAP_BYTES - HEADER_BYTES), free: 1'b1,
                  next: LW'(MAX_BLOCKS), prev: LW'(MAX_BLOCKS)};
      end
      A_PWR: begin
        we         = 1'b1;
        waddr      = cur.prev[IW-1:0];
        wdata.size = SW'(CW'(rdata.size) + CW'(pad));
      end
      A_NEW: begin
        we    = 1'b1;
        waddr = nb;
        wdata = '{hdr:  SW'(alloc_data + CW'(rsize)),
                  size: SW'(CW'(cur.size) - CW'(pad) - need),
                  free: 1'b1, next: cur.next, prev: b};
      end
      A_BWR: begin
        we    = 1'b1;
        waddr = b[IW-1:0];
        wdata = '{hdr: SW'(CW'(cur.hdr) + CW'(pad)), size: SW'(rsize), free: 1'b0,
                  next: LW'(nb), prev: cur.prev};
      end
      U_WR: begin
        we         = 1'b1;
        waddr      = ulink[IW-1:0];
        wdata.prev = uval;
      end
      F_PWR: begin
        we    = 1'b1;
        waddr = cur.prev[IW-1:0];
        wdata = oth;
      end
      F_BWR: begin
        we         = 1'b1;
        waddr      = b[IW-1:0];
        wdata      = cur;
        wdata.free = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= INIT;
      in_use    <= MAX_BLOCKS'(1);
      rsp.valid <= 1'b0;
    end else begin
      // DONE reloads the output register itself
      if (rsp.valid && rsp.ready && (st != DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (st)
        INIT: st <= IDLE;
        IDLE: begin
          if (req.valid) begin
            rsize  <= req.req_size;
            ralign <= req.req_align;
            roff   <= req.free_offset;
            b      <= '0;
            cnt    <= '0;
            s      <= '0;
            pad    <= '0;
            st     <= (req.func == ffha_pkg::FUNC_ALLOC) ? A_RD : F_RD;
          end
        end
        // ---- allocate: first-fit walk
        A_RD: begin
          if ((cnt < CNTW'(MAX_BLOCKS)) && link_ok(b, in_use)) begin
            cnt <= cnt + CNTW'(1);
            st  <= A_CHK;
          end else begin
            res_off <= '0;
            res_st  <= ffha_pkg::ST_NO_SPACE;
            st      <= DONE;
          end
        end
        A_CHK: begin
          cur <= rdata;
          pad <= '0;
          if (!fit0) begin
            b  <= rdata.next;
            st <= A_RD;
          end else if (ralign > AW'(1)) begin
            st <= A_MOD;
          end else begin
            s  <= '0;
            st <= A_SLOT;
          end
        end
        A_MOD: begin
          if (mod_done) begin
            if (fit1) begin
              pad <= pad_v;
              s   <= '0;
              st  <= A_SLOT;
            end else begin
              b  <= cur.next;
              st <= A_RD;
            end
          end
        end
        A_SLOT: begin
          if (!in_use[s]) begin
            nb <= s;
            st <= ((pad != '0) && link_ok(cur.prev, in_use)) ? A_PRD : A_NEW;
          end else if (s == IW'(MAX_BLOCKS - 1)) begin
            res_off <= '0;
            res_st  <= ffha_pkg::ST_TABLE_FULL;
            st      <= DONE;
          end else begin
            s <= s + IW'(1);
          end
        end
        A_PRD: st <= A_PWR;
        A_PWR: st <= A_NEW;
        A_NEW: begin
          in_use[nb] <= 1'b1;
          if (link_ok(cur.next, in_use)) begin
            ulink <= cur.next;
            uval  <= LW'(nb);
            ret   <= A_BWR;
            st    <= U_RD;
          end else begin
            st <= A_BWR;
          end
        end
        A_BWR: begin
          res_off <= alloc_data[ffha_pkg::OFFSET_W-1:0];
          res_st  <= ffha_pkg::ST_OK;
          st      <= DONE;
        end
        // ---- free: find the block by its data offset
        F_RD: st <= F_CK;
        F_CK: begin
          if (in_use[s] && !rdata.free &&
              ((CW'(rdata.hdr) + CW'(HEADER_BYTES)) == CW'(roff))) begin
            b   <= LW'(s);
            cur <= rdata;
            st  <= link_ok(rdata.next, in_use) ? F_XRD : F_PRE;
          end else if (s == IW'(MAX_BLOCKS - 1)) begin
            res_off <= '0;
            res_st  <= ffha_pkg::ST_BAD_FREE;
            st      <= DONE;
          end else begin
            s  <= s + IW'(1);
            st <= F_RD;
          end
        end
        F_XRD: st <= F_XCK;
        F_XCK: begin
          // merge with a free next neighbor
          if (rdata.free) begin
            cur <= '{hdr:  cur.hdr,
                     size: SW'(CW'(cur.size) + CW'(HEADER_BYTES) + CW'(rdata.size)),
                     free: cur.free, next: rdata.next, prev: cur.prev};
            in_use[cur.next[IW-1:0]] <= 1'b0;
            if (link_ok(rdata.next, in_use)) begin
              ulink <= rdata.next;
              uval  <= b;
              ret   <= F_PRE;
              st    <= U_RD;
            end else begin
              st <= F_PRE;
            end
          end else begin
            st <= F_PRE;
          end
        end
        F_PRE: st <= link_ok(cur.prev, in_use) ? F_PRD : F_BWR;
        F_PRD: st <= F_PCK;
        F_PCK: begin
          // merge into a free previous neighbor
          if (rdata.free) begin
            oth <= '{hdr:  rdata.hdr,
                     size: SW'(CW'(rdata.size) + CW'(HEADER_BYTES) + CW'(cur.size)),
                     free: rdata.free, next: cur.next, prev: rdata.prev};
            in_use[b[IW-1:0]] <= 1'b0;
            if (link_ok(cur.next, in_use)) begin
              ulink <= cur.next;
              uval  <= cur.prev;
              ret   <= F_PWR;
              st    <= U_RD;
            end else begin
              st <= F_PWR;
            end
          end else begin
            st <= F_BWR;
          end
        end
        F_PWR,
        F_BWR: begin
          res_off <= '0;
          res_st  <= ffha_pkg::ST_OK;
          st      <= DONE;
        end
        // ---- prev-link update of a neighbor, read-modify-write
        U_RD: st <= U_WR;
        U_WR: st <= ret;
        DONE: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.data_offset <= res_off;
            rsp.status      <= res_st;
            st              <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

endmodule
